>>> hdl/kcs_pkg.sv
// Package: types, constants and codes shared by the keyframe curve sampler.
package kcs_pkg;

  localparam int unsigned MaxKeys = 64;
  localparam int unsigned IdxW = $clog2(MaxKeys);
  localparam int unsigned CntW = $clog2(MaxKeys + 1);

  localparam logic [1:0] ReqClear  = 2'd0;
  localparam logic [1:0] ReqAppend = 2'd1;
  localparam logic [1:0] ReqSample = 2'd2;

  localparam logic [2:0] StSampled = 3'd0;
  localparam logic [2:0] StDefault = 3'd1;
  localparam logic [2:0] StStored  = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StCleared = 3'd4;

  localparam logic CfgInterpStep = 1'b0;
  localparam logic CfgMinSpan    = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic signed [31:0] query_time;
    logic signed [31:0] default_x;
    logic signed [31:0] default_y;
    logic signed [31:0] default_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [2:0]         status;
  } rsp_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic            load;     // capture input item
    logic            append;   // write key at count
    logic            clear;    // zero key count
    logic            rd_en;    // read entry at rd_idx
    logic [IdxW-1:0] rd_idx;
    logic            cap_left; // latch read data as left key
    logic            cap_right;
    logic            div_start;
    logic            mul_start;
    logic            out_zero; // result: zeros with status
    logic            out_left; // result: key value on the read register
    logic            out_dflt; // result: defaults
    logic            out_blend;
    logic [2:0]      status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0]      req_type;
    logic [CntW-1:0] count;
    logic            t_le_rd;  // query <= time of data read last cycle
    logic            t_ge_rd;  // query >= time of data read last cycle
    logic            interp_step;
    logic            div_done;
    logic            mul_done;
  } sts_t;

endpackage

>>> hdl/kcs_datapath.sv
// Datapath: key storage, search compare, serial divider and blend multipliers.
module kcs_datapath
  import kcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output rsp_t        rsp_o
);

  logic signed [31:0] t_mem [MaxKeys];
  logic signed [31:0] x_mem [MaxKeys];
  logic signed [31:0] y_mem [MaxKeys];
  logic signed [31:0] z_mem [MaxKeys];

  req_t               req_q;
  logic [CntW-1:0]    count_q;
  logic               step_q;
  logic [15:0]        min_span_q;
  logic signed [31:0] rd_t_q, rd_x_q, rd_y_q, rd_z_q;
  logic signed [31:0] t0_q, x0_q, y0_q, z0_q;
  logic signed [31:0] t1_q, x1_q, y1_q, z1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      step_q     <= 1'b0;
      min_span_q <= 16'd7;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgInterpStep) step_q <= cfg_data_i[0];
        else min_span_q <= cfg_data_i;
      end
      if (cmd_i.clear) count_q <= '0;
      else if (cmd_i.append) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.append) begin
      t_mem[count_q[IdxW-1:0]] <= req_q.key_time;
      x_mem[count_q[IdxW-1:0]] <= req_q.key_x;
      y_mem[count_q[IdxW-1:0]] <= req_q.key_y;
      z_mem[count_q[IdxW-1:0]] <= req_q.key_z;
    end
    if (cmd_i.rd_en) begin
      rd_t_q <= t_mem[cmd_i.rd_idx];
      rd_x_q <= x_mem[cmd_i.rd_idx];
      rd_y_q <= y_mem[cmd_i.rd_idx];
      rd_z_q <= z_mem[cmd_i.rd_idx];
    end
    if (cmd_i.cap_left) begin
      t0_q <= rd_t_q; x0_q <= rd_x_q; y0_q <= rd_y_q; z0_q <= rd_z_q;
    end
    if (cmd_i.cap_right) begin
      t1_q <= rd_t_q; x1_q <= rd_x_q; y1_q <= rd_y_q; z1_q <= rd_z_q;
    end
  end

  // Restoring divider: fraction = ((t - t0) << 16) / (t1 - t0), 49-bit dividend.
  localparam int unsigned DivN = 49;
  logic [DivN-1:0] quo_q;
  logic [33:0]     rem_q;
  logic [32:0]     dvs_q;
  logic [5:0]      div_cnt_q;
  logic            div_busy_q, div_done_q;
  logic [16:0]     frac_q;
  logic [32:0]     span_w, off_w;
  logic [33:0]     rem_sh, rem_sub;

  assign span_w  = 33'($signed(t1_q)) - 33'($signed(t0_q));
  assign off_w   = 33'($signed(req_q.query_time)) - 33'($signed(t0_q));
  assign rem_sh  = {rem_q[32:0], quo_q[DivN-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (cmd_i.div_start) begin
        if ($signed(span_w) > $signed({17'd0, min_span_q})) begin
          div_busy_q <= 1'b1;
          div_cnt_q  <= 6'(DivN);
        end else begin
          div_done_q <= 1'b1;
        end
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == 6'd1) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= {off_w[32:0], 16'd0};
      rem_q  <= '0;
      dvs_q  <= span_w;
      frac_q <= '0;
    end else if (div_busy_q) begin
      if (!rem_sub[33]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[DivN-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivN-2:0], 1'b0};
      end
      if (div_cnt_q == 6'd1) frac_q <= {quo_q[15:0], !rem_sub[33]};
    end
  end

  // Blend: three 33x18 signed products, registered, then floor shift and add.
  logic signed [50:0] px_q, py_q, pz_q;
  logic               mul_done_q;
  logic signed [17:0] f_s;
  assign f_s = {1'b0, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_done_q <= 1'b0;
    else mul_done_q <= cmd_i.mul_start;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      px_q <= 51'((33'($signed(x1_q)) - 33'($signed(x0_q))) * f_s);
      py_q <= 51'((33'($signed(y1_q)) - 33'($signed(y0_q))) * f_s);
      pz_q <= 51'((33'($signed(z1_q)) - 33'($signed(z0_q))) * f_s);
    end
  end

  // Arithmetic shift floors for both signs.
  logic signed [31:0] bx, by, bz;
  assign bx = x0_q + 32'(px_q >>> 16);
  assign by = y0_q + 32'(py_q >>> 16);
  assign bz = z0_q + 32'(pz_q >>> 16);

  rsp_t rsp_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_zero) rsp_q <= '{out_x: '0, out_y: '0, out_z: '0, status: cmd_i.status};
    else if (cmd_i.out_dflt)
      rsp_q <= '{out_x: req_q.default_x, out_y: req_q.default_y,
                 out_z: req_q.default_z, status: cmd_i.status};
    else if (cmd_i.out_left)
      rsp_q <= '{out_x: rd_x_q, out_y: rd_y_q, out_z: rd_z_q, status: cmd_i.status};
    else if (cmd_i.out_blend)
      rsp_q <= '{out_x: bx, out_y: by, out_z: bz, status: cmd_i.status};
  end
  assign rsp_o = rsp_q;

  assign sts_o.req_type    = req_q.req_type;
  assign sts_o.count       = count_q;
  assign sts_o.t_le_rd     = req_q.query_time <= rd_t_q;
  assign sts_o.t_ge_rd     = req_q.query_time >= rd_t_q;
  assign sts_o.interp_step = step_q;
  assign sts_o.div_done    = div_done_q;
  assign sts_o.mul_done    = mul_done_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxKeys)) else $error("key count above table size");
  a_div_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> !cmd_i.mul_start) else $error("multiply while dividing");
  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_q |=> frac_q <= 17'h10000) else $error("fraction above one");
`endif

endmodule

>>> hdl/kcs_ctrl.sv
// Controller: request decode, segment search sequencing and output handshake.
module kcs_ctrl
  import kcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_RDF   = 11'b00000000100, // not entered; S_DEC reads the first key
    S_CHKF  = 11'b00000001000,
    S_CHKL  = 11'b00000010000, // last key on rd
    S_RDL   = 11'b00000100000, // left of segment on rd
    S_RDR   = 11'b00001000000, // right of segment on rd
    S_DIV   = 11'b00010000000,
    S_MUL   = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            ov_q, ov_d;
  logic [CntW-1:0] last_w;

  assign last_w = sts_i.count - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE) || (ov_q && out_stall_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ov_d    = ov_q && out_stall_i;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts_i.req_type == ReqClear) begin
          cmd_o.clear = 1'b1; cmd_o.out_zero = 1'b1; cmd_o.status = StCleared;
          state_d = S_WAIT;
        end else if (sts_i.req_type == ReqAppend) begin
          cmd_o.out_zero = 1'b1;
          if (sts_i.count >= CntW'(MaxKeys)) cmd_o.status = StFull;
          else begin
            cmd_o.append = 1'b1; cmd_o.status = StStored;
          end
          state_d = S_WAIT;
        end else if (sts_i.req_type == ReqSample) begin
          if (sts_i.count == '0) begin
            cmd_o.out_dflt = 1'b1; cmd_o.status = StDefault;
            state_d = S_WAIT;
          end else begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = '0;
            state_d = S_CHKF;
          end
        end else begin
          state_d = S_IDLE; // unused code: drop silently
        end
      end
      S_CHKF: begin
        if (sts_i.count == CntW'(1) || sts_i.t_le_rd) begin
          cmd_o.out_left = 1'b1; cmd_o.status = StSampled;
          state_d = S_WAIT;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_idx = last_w[IdxW-1:0];
          state_d = S_CHKL;
        end
      end
      S_CHKL: begin
        if (sts_i.t_ge_rd) begin
          cmd_o.out_left = 1'b1; cmd_o.status = StSampled;
          state_d = S_WAIT;
        end else begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_idx = '0; idx_d = '0;
          state_d = S_RDL;
        end
      end
      S_RDL: begin
        // Left key of segment idx is on the read register.
        if (sts_i.t_ge_rd) begin
          cmd_o.cap_left = 1'b1;
          cmd_o.rd_en = 1'b1; cmd_o.rd_idx = idx_q + 1'b1;
          state_d = S_RDR;
        end else begin
          idx_d = idx_q + 1'b1;
          if ({1'b0, idx_q} + 1'b1 >= last_w) begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = last_w[IdxW-1:0];
            state_d = S_OUT;
          end else begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = idx_q + 1'b1;
          end
        end
      end
      S_RDR: begin
        if (sts_i.t_le_rd) begin
          cmd_o.cap_right = 1'b1;
          if (sts_i.interp_step) begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = idx_q;
            state_d = S_OUT;
          end else state_d = S_DIV;
        end else begin
          // right key becomes next left candidate
          idx_d = idx_q + 1'b1;
          if ({1'b0, idx_q} + 1'b1 >= last_w) begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = last_w[IdxW-1:0];
            state_d = S_OUT;
          end else begin
            cmd_o.rd_en = 1'b1; cmd_o.rd_idx = idx_q + 1'b1;
            state_d = S_RDL;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (sts_i.div_done) begin
          cmd_o.mul_start = 1'b1;
          state_d = S_WAIT;
          idx_d = '1;
        end
      end
      S_OUT: begin
        cmd_o.out_left = 1'b1; cmd_o.status = StSampled;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.out_blend = 1'b1; cmd_o.status = StSampled;
        end else begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !ov_q || !out_stall_i) else $error("accept over pending result");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && !sts_i.mul_done) |=> ov_q) else $error("result lost");
`endif

endmodule

>>> hdl/keyframe_curve_sampler.sv
// Clear, append and empty sample answer straight from decode. A sample at or before the
// first key returns the first key, one at or after the last key returns the last key.
// A segment sample walks the table one segment at a time, then runs the divider and the
// blend (in step mode it returns the left key instead). One item at a time: the next
// transfer is taken at the edge the result leaves. Reset clears the key count, state and
// handshake and loads interp_step 0 and min_span 7; key storage is not cleared.
module keyframe_curve_sampler
  import kcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o
);

  cmd_t cmd;
  sts_t sts;

  kcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  kcs_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule
